/* hdl/bmsi_pkg.sv */
// Types and constants shared by the banked mapper with scanline interrupt.
package bmsi_pkg;

    localparam int RAM_WORDS         = 1024;
    localparam int RAM_AW            = $clog2(RAM_WORDS);
    localparam int A12_FILTER_CYCLES = 8;
    localparam int FILTER_W          = 4;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_PPU   = 2'd2;

    localparam logic [1:0] REG_BANK      = 2'd0;
    localparam logic [1:0] REG_MIRROR    = 2'd1;
    localparam logic [1:0] REG_IRQ_LATCH = 2'd2;
    localparam logic [1:0] REG_IRQ_EN    = 2'd3;

    localparam logic [2:0] BANK_CHR_0_1 = 3'd0;
    localparam logic [2:0] BANK_CHR_2_3 = 3'd1;
    localparam logic [2:0] BANK_CHR_4   = 3'd2;
    localparam logic [2:0] BANK_CHR_5   = 3'd3;
    localparam logic [2:0] BANK_CHR_6   = 3'd4;
    localparam logic [2:0] BANK_CHR_7   = 3'd5;
    localparam logic [2:0] BANK_PRG_0   = 3'd6;
    localparam logic [2:0] BANK_PRG_1   = 3'd7;

    localparam logic [7:0] PRG_FIXED_C000 = 8'h3E;
    localparam logic [7:0] PRG_FIXED_E000 = 8'h3F;
    localparam logic [7:0] CHR_PAIR_MASK  = 8'hFE;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       open_bus;
        logic [7:0] bank;
        logic       irq;
        logic       mirror_horizontal;
    } t_out;

    typedef struct packed {
        logic       step;
        logic       ppu;
        logic       a12;
        logic       latch_we;
        logic       reload_set;
        logic       en_set;
        logic       en_clr;
        logic [7:0] data;
    } t_irq_ctl;

endpackage

/* hdl/bmsi_ram.sv */
// Generic single-port-write, registered-read RAM.
module bmsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/bmsi_irq.sv */
// Filtered A12 edge detector and scanline interrupt counter.
module bmsi_irq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmsi_pkg::t_irq_ctl i_ctl,
    output logic              o_irq_next
);
    import bmsi_pkg::*;

    logic [FILTER_W-1:0] r_filter, n_filter;
    logic [7:0]          r_count, n_count;
    logic [7:0]          r_latch, n_latch;
    logic                r_reload, n_reload;
    logic                r_enable, n_enable;
    logic                r_line, n_line;
    logic [FILTER_W-1:0] filter_dec;

    always_comb begin
        n_filter   = r_filter;
        n_count    = r_count;
        n_latch    = r_latch;
        n_reload   = r_reload;
        n_enable   = r_enable;
        n_line     = r_line;
        filter_dec = (r_filter != '0) ? r_filter - 1'b1 : r_filter;
        if (i_ctl.latch_we) begin
            n_latch = i_ctl.data;
        end
        if (i_ctl.reload_set) begin
            n_reload = 1'b1;
        end
        if (i_ctl.en_set) begin
            n_enable = 1'b1;
        end
        if (i_ctl.en_clr) begin
            n_enable = 1'b0;
            n_line   = 1'b0;
        end
        if (i_ctl.ppu) begin
            n_filter = filter_dec;
            if (filter_dec == '0 && i_ctl.a12) begin
                if (r_count == '0 || r_reload) begin
                    n_count  = r_latch;
                    n_reload = 1'b0;
                end else begin
                    n_count = r_count - 8'd1;
                end
                if (n_count == '0 && r_enable) begin
                    n_line = 1'b1;
                end
            end
            if (i_ctl.a12) begin
                n_filter = FILTER_W'(A12_FILTER_CYCLES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= '0;
            r_count  <= '0;
            r_latch  <= '0;
            r_reload <= 1'b0;
            r_enable <= 1'b0;
            r_line   <= 1'b0;
        end else if (i_ctl.step) begin
            r_filter <= n_filter;
            r_count  <= n_count;
            r_latch  <= n_latch;
            r_reload <= n_reload;
            r_enable <= n_enable;
            r_line   <= n_line;
        end
    end

    assign o_irq_next = n_line;
endmodule

/* hdl/banked_mapper_scanline_irq.sv */
// Top level of the banked cartridge mapper with scanline interrupt counter.
// Input channel (i_valid, o_ready, i_item) carries one CPU write, CPU read or
// PPU bus cycle per item; output channel (o_valid, i_ready, o_item) returns
// one result per item: read data or open bus, the mapped bank, the interrupt
// line and the mirroring, all as they stand after the item.
// An item passes through the input register, whose cycle also reads the 1 KiB
// work RAM, and then the result register before o_valid offers its result.
// Throughput is one item per cycle while i_ready is high; the work RAM's single
// read port and the bank, command and counter registers are updated in the same cycle.
// A RAM write by one item is forwarded to a read by the item right behind it.
// Reset clears the bank registers to their power-on mapping, disables the work
// RAM and the interrupt and empties both registers; the RAM contents are kept.
// When the receiver stalls the result waits in the output register, the next
// item waits in the input register, and o_ready falls only when both are full.
module banked_mapper_scanline_irq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bmsi_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output bmsi_pkg::t_out o_item
);
    import bmsi_pkg::*;

    t_in         r_in;
    logic        r_v;
    t_out        r_out, n_out;
    logic        r_ov;
    logic        r_byp;
    logic [7:0]  r_byp_data;

    logic [7:0]  r_chr [8];
    logic [7:0]  n_chr [8];
    logic [5:0]  r_prg [2];
    logic [5:0]  n_prg [2];
    logic [7:0]  r_cmd_reg, n_cmd_reg;
    logic [7:0]  r_ram_en, n_ram_en;
    logic        r_mirror, n_mirror;

    logic        adv;
    logic        accept;
    logic        ram_we;
    logic [7:0]  ram_rdata;
    logic [7:0]  ram_q;
    logic        in_ram_win;
    logic [2:0]  chr_slot;
    logic [1:0]  prg_slot;
    t_irq_ctl    irq_ctl;
    logic        irq_next;

    assign adv     = r_v && (!r_ov || i_ready);
    assign o_ready = !r_v || adv;
    assign accept  = i_valid && o_ready;

    assign in_ram_win = (r_in.addr[15:12] == 4'h7);
    assign ram_q      = r_byp ? r_byp_data : ram_rdata;
    assign chr_slot   = r_in.addr[12:10] ^ {r_cmd_reg[7], 2'b00};
    assign prg_slot   = {r_in.addr[14] ^ (n_cmd_reg[6] & ~r_in.addr[13]), r_in.addr[13]};

    bmsi_ram #(
        .WIDTH (8),
        .DEPTH (RAM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (adv && ram_we),
        .i_waddr (r_in.addr[RAM_AW-1:0]),
        .i_wdata (r_in.data),
        .i_re    (accept),
        .i_raddr (i_item.addr[RAM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    bmsi_irq u_irq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (irq_ctl),
        .o_irq_next (irq_next)
    );

    always_comb begin
        n_chr     = r_chr;
        n_prg     = r_prg;
        n_cmd_reg = r_cmd_reg;
        n_ram_en  = r_ram_en;
        n_mirror  = r_mirror;
        ram_we    = 1'b0;
        irq_ctl      = '0;
        irq_ctl.step = adv;
        irq_ctl.a12  = r_in.addr[12];
        irq_ctl.data = r_in.data;
        n_out     = '0;

        unique case (r_in.cmd)
            CMD_WRITE: begin
                if (in_ram_win) begin
                    ram_we = r_in.addr[9] ? (r_ram_en[7] & r_ram_en[6])
                                          : (r_ram_en[5] & r_ram_en[4]);
                end else if (r_in.addr[15]) begin
                    unique case (r_in.addr[14:13])
                        REG_BANK: begin
                            if (r_in.addr[0]) begin
                                unique case (r_cmd_reg[2:0])
                                    BANK_CHR_0_1: begin
                                        n_chr[0] = r_in.data & CHR_PAIR_MASK;
                                        n_chr[1] = r_in.data | 8'h01;
                                    end
                                    BANK_CHR_2_3: begin
                                        n_chr[2] = r_in.data & CHR_PAIR_MASK;
                                        n_chr[3] = r_in.data | 8'h01;
                                    end
                                    BANK_CHR_4: n_chr[4] = r_in.data;
                                    BANK_CHR_5: n_chr[5] = r_in.data;
                                    BANK_CHR_6: n_chr[6] = r_in.data;
                                    BANK_CHR_7: n_chr[7] = r_in.data;
                                    BANK_PRG_0: n_prg[0] = r_in.data[5:0];
                                    BANK_PRG_1: n_prg[1] = r_in.data[5:0];
                                    default:    n_prg[1] = r_in.data[5:0];
                                endcase
                            end else begin
                                n_cmd_reg = r_in.data;
                                if (r_in.data[5]) begin
                                    n_ram_en[0] = 1'b1;
                                end
                            end
                        end
                        REG_MIRROR: begin
                            if (r_in.addr[0]) begin
                                if (r_ram_en[0]) begin
                                    n_ram_en = r_in.data | 8'h01;
                                end
                            end else begin
                                n_mirror = r_in.data[0];
                            end
                        end
                        REG_IRQ_LATCH: begin
                            irq_ctl.reload_set = r_in.addr[0];
                            irq_ctl.latch_we   = !r_in.addr[0];
                        end
                        REG_IRQ_EN: begin
                            irq_ctl.en_set = r_in.addr[0];
                            irq_ctl.en_clr = !r_in.addr[0];
                        end
                        default: ;
                    endcase
                end
            end
            CMD_READ: begin
                if (in_ram_win) begin
                    if (r_ram_en[7] || r_ram_en[5]) begin
                        if (r_in.addr[9] ? r_ram_en[7] : r_ram_en[5]) begin
                            n_out.read_data = ram_q;
                        end
                    end else begin
                        n_out.open_bus = 1'b1;
                    end
                end else if (!r_in.addr[15]) begin
                    n_out.open_bus = 1'b1;
                end
            end
            CMD_PPU: begin
                irq_ctl.ppu = 1'b1;
                if (!r_in.addr[13]) begin
                    n_out.bank = r_chr[chr_slot];
                end
            end
            default: ;
        endcase

        if ((r_in.cmd == CMD_WRITE || r_in.cmd == CMD_READ) && r_in.addr[15]) begin
            case (prg_slot)
                2'd0:    n_out.bank = {2'b00, n_prg[0]};
                2'd1:    n_out.bank = {2'b00, n_prg[1]};
                2'd2:    n_out.bank = PRG_FIXED_C000;
                default: n_out.bank = PRG_FIXED_E000;
            endcase
        end

        n_out.irq               = irq_next;
        n_out.mirror_horizontal = n_mirror;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chr[i] <= 8'(i);
            end
            r_prg[0]  <= 6'd0;
            r_prg[1]  <= 6'd1;
            r_cmd_reg <= '0;
            r_ram_en  <= '0;
            r_mirror  <= 1'b0;
        end else begin
            if (accept) begin
                r_v <= 1'b1;
            end else if (adv) begin
                r_v <= 1'b0;
            end
            if (adv) begin
                r_ov      <= 1'b1;
                r_chr     <= n_chr;
                r_prg     <= n_prg;
                r_cmd_reg <= n_cmd_reg;
                r_ram_en  <= n_ram_en;
                r_mirror  <= n_mirror;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in       <= i_item;
            r_byp      <= adv && ram_we && (r_in.addr[RAM_AW-1:0] == i_item.addr[RAM_AW-1:0]);
            r_byp_data <= r_in.data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !adv |=> r_v)
        else $error("Pending item dropped while stalled.");

    a_ram_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && ram_we |-> r_in.cmd == CMD_WRITE && r_in.addr[15:12] == 4'h7)
        else $error("Work RAM written outside its window.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("Pipeline not empty after reset.");

    a_irq_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.cmd == CMD_WRITE && r_in.addr[15:13] == 3'b111 && !r_in.addr[0]
        |=> o_valid && !o_item.irq)
        else $error("Interrupt not released by disable write.");
endmodule
